// ===== src/itlr_pkg.sv =====
`default_nettype none
package itlr_pkg;

    localparam int SETS  = 64;
    localparam int WAYS  = 4;
    localparam int SET_W = 6;
    localparam int WAY_W = 2;
    localparam int TAG_W = 21;
    localparam int ADDR_W = 32;

    // address split: line offset below, set above it, tag on top
    localparam int SET_LSB = 5;
    localparam int TAG_LSB = SET_LSB + SET_W;

    localparam logic [31:0] SEED_RESET = 32'd44203;
    localparam logic [31:0] SEED_MUL_A = 32'd17;
    localparam logic [31:0] SEED_MUL_B = 32'd7;
    localparam int          RND_LSB    = 17;

    typedef enum logic [1:0] {
        MODE_LOOKUP    = 2'd0,
        MODE_INVAL     = 2'd1,
        MODE_INVAL_ALL = 2'd2
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] fetch_address;
    } in_item_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic [SET_W-1:0] set_index;
        logic             refill;
    } out_item_t;

    // tag store update for one evaluated item
    typedef struct packed {
        logic             fill;
        logic             inval;
        logic             inval_all;
        logic [SET_W-1:0] set;
        logic [WAY_W-1:0] way;
        logic [TAG_W-1:0] tag;
    } tag_wr_t;

    // replacement state update
    typedef struct packed {
        logic             rr_step;
        logic             rnd_step;
        logic [SET_W-1:0] set;
    } victim_upd_t;

endpackage
`default_nettype wire

// ===== src/itlr_tag_store.sv =====
`default_nettype none
module itlr_tag_store
    import itlr_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [SET_W-1:0]            rd_set,
    output logic      [WAYS-1:0][TAG_W-1:0]  rd_tags,
    input  wire logic [SET_W-1:0]            valid_set,
    output logic      [WAYS-1:0]             valid_ways,
    input  wire tag_wr_t                     wr
);

    logic [WAYS-1:0][TAG_W-1:0] tag_mem [SETS];
    logic [WAYS-1:0][TAG_W-1:0] rd_tags_reg;
    logic [WAYS-1:0]            valid_reg [SETS];

    always_ff @(posedge clk)
    begin
        if (wr.fill)
        begin
            tag_mem[wr.set][wr.way] <= wr.tag;
        end
        if (rd_en)
        begin
            rd_tags_reg <= tag_mem[rd_set];
        end
    end

    // valid bits live in flops so invalidate-all clears them all at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SETS; i++)
            begin
                valid_reg[i] <= '0;
            end
        end
        else if (wr.inval_all)
        begin
            for (int i = 0; i < SETS; i++)
            begin
                valid_reg[i] <= '0;
            end
        end
        else if (wr.fill)
        begin
            valid_reg[wr.set][wr.way] <= 1'b1;
        end
        else if (wr.inval)
        begin
            valid_reg[wr.set][wr.way] <= 1'b0;
        end
    end

    assign rd_tags    = rd_tags_reg;
    assign valid_ways = valid_reg[valid_set];

endmodule
`default_nettype wire

// ===== src/itlr_victim.sv =====
`default_nettype none
module itlr_victim
    import itlr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [SET_W-1:0] rd_set,
    input  wire victim_upd_t      upd,
    output logic      [WAY_W-1:0] rr_way,
    output logic      [WAY_W-1:0] rnd_way
);

    logic [WAY_W-1:0] cnt_mem [SETS];
    logic [WAY_W-1:0] cnt_rd_reg;
    logic             cnt_known_reg;
    logic [SETS-1:0]  cnt_valid_reg;
    logic [31:0]      seed_reg;
    logic [31:0]      seed_next;

    always_ff @(posedge clk)
    begin
        if (upd.rr_step)
        begin
            cnt_mem[upd.set] <= rr_way + WAY_W'(1);
        end
        if (rd_en)
        begin
            cnt_rd_reg <= cnt_mem[rd_set];
        end
    end

    // a counter never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= '0;
            cnt_known_reg <= 1'b0;
            seed_reg      <= SEED_RESET;
        end
        else
        begin
            if (rd_en)
            begin
                cnt_known_reg <= cnt_valid_reg[rd_set];
            end
            if (upd.rr_step)
            begin
                cnt_valid_reg[upd.set] <= 1'b1;
            end
            if (upd.rnd_step)
            begin
                seed_reg <= seed_next;
            end
        end
    end

    assign seed_next = seed_reg ^ 32'(seed_reg * SEED_MUL_A) ^ 32'(seed_reg * SEED_MUL_B);
    assign rnd_way   = seed_next[RND_LSB +: WAY_W];
    assign rr_way    = cnt_known_reg ? cnt_rd_reg : '0;

endmodule
`default_nettype wire

// ===== src/icache_tag_lookup_replace.sv =====
// Tag array of a 4-way, 64-set instruction cache with 32-byte lines.
// Input channel (in_valid/in_ready/in_data) carries a mode and a fetch
// address: lookup with fill on miss, invalidate by address, or
// invalidate all. Each input beat yields exactly one output beat
// (out_valid/out_ready/out_data) with hit, way, set index and refill.
// The config channel (cfg_valid/cfg_ready/cfg_data) sets the victim
// policy: 1 round-robin per set, 0 pseudo-random; write it while idle.
// An accepted item reads the set's tag row and victim counter from
// synchronous RAM, then in evaluation compares, writes back and loads
// the output register once that register is free. No new item is
// accepted before the last one is loaded, since the RAM read comes
// ahead of the read-modify-write of the same row.
// The output register holds a result while out_ready is low; the next
// item may be accepted meanwhile but waits in evaluation until the
// register frees, and no further input is taken until then.
// Reset clears all valid bits and victim counters at once, loads the
// random seed and selects random replacement; no clearing pass runs.
`default_nettype none
module icache_tag_lookup_replace
    import itlr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_data
);

    state_t      state_reg, state_next;
    in_item_t    item_reg;
    out_item_t   out_reg, out_next;
    logic        out_valid_reg;
    logic        rr_en_reg;

    logic                       in_fire;
    logic                       load;
    logic [SET_W-1:0]           set_q;
    logic [TAG_W-1:0]           tag_q;
    logic [WAYS-1:0][TAG_W-1:0] rd_tags;
    logic [WAYS-1:0]            valid_ways;
    logic [WAYS-1:0]            match;
    logic                       any_match;
    logic [WAY_W-1:0]           match_way;
    logic [WAY_W-1:0]           rr_way;
    logic [WAY_W-1:0]           rnd_way;
    logic [WAY_W-1:0]           victim_way;
    tag_wr_t                    wr;
    victim_upd_t                upd;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign set_q     = item_reg.fetch_address[TAG_LSB-1:SET_LSB];
    assign tag_q     = item_reg.fetch_address[ADDR_W-1:TAG_LSB];

    itlr_tag_store u_tags (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (in_fire),
        .rd_set     (in_data.fetch_address[TAG_LSB-1:SET_LSB]),
        .rd_tags    (rd_tags),
        .valid_set  (set_q),
        .valid_ways (valid_ways),
        .wr         (wr)
    );

    itlr_victim u_victim (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_set  (in_data.fetch_address[TAG_LSB-1:SET_LSB]),
        .upd     (upd),
        .rr_way  (rr_way),
        .rnd_way (rnd_way)
    );

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = valid_ways[w] && (rd_tags[w] == tag_q);
        end
    end

    // lowest matching way wins
    always_comb
    begin
        match_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                match_way = WAY_W'(w);
            end
        end
    end

    assign any_match  = |match;
    assign victim_way = rr_en_reg ? rr_way : rnd_way;
    assign load       = (state_reg == ST_EVAL) && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_next           = '0;
        out_next.set_index = set_q;
        wr                 = '0;
        wr.set             = set_q;
        wr.tag             = tag_q;
        upd                = '0;
        upd.set            = set_q;
        case (mode_t'(item_reg.mode))
            MODE_LOOKUP:
            begin
                if (any_match)
                begin
                    out_next.hit = 1'b1;
                    out_next.way = match_way;
                end
                else
                begin
                    out_next.way    = victim_way;
                    out_next.refill = 1'b1;
                    wr.fill         = load;
                    upd.rr_step     = load && rr_en_reg;
                    upd.rnd_step    = load && !rr_en_reg;
                end
                wr.way = out_next.way;
            end
            MODE_INVAL:
            begin
                out_next.hit = any_match;
                out_next.way = match_way;
                wr.way       = match_way;
                wr.inval     = load && any_match;
            end
            MODE_INVAL_ALL:
            begin
                wr.inval_all = load;
            end
            default:
            begin
                // unused mode: report set only, touch nothing
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rr_en_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                rr_en_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // an accepted beat always moves into evaluation
    a_fire_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EVAL))
        else $error("accepted beat did not enter evaluation");

    // a result load always presents a beat next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("loaded result not presented");

    // a refill is only reported on a miss
    a_refill_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.hit && out_data.refill))
        else $error("refill reported together with hit");

    // tag store never sees two kinds of update at once
    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({wr.fill, wr.inval, wr.inval_all}))
        else $error("conflicting tag store updates");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import itlr_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         LINES       = SETS * WAYS;

    // Shadow copy of the tag array; predicts one result beat per fetch beat
    class tag_array_shadow;
        logic [TAG_W-1:0] line_tag [LINES];
        bit               line_valid [LINES];
        logic [WAY_W-1:0] rr_ptr [SETS];
        logic [31:0]      rnd_seed;
        bit               rr_mode;
        out_item_t        expected_beats [$];
        int               mismatches;

        function new();
            int i;
            for (i = 0; i < LINES; i++)
            begin
                line_tag[i]   = '0;
                line_valid[i] = 1'b0;
            end
            for (i = 0; i < SETS; i++)
                rr_ptr[i] = '0;
            rnd_seed    = SEED_RESET;
            rr_mode     = 1'b0;
            mismatches  = 0;
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("mismatch %0d at %0t: %s got %0h want %0h",
                     mismatches, $realtime, field, got, want);
        endtask

        function int pending();
            return expected_beats.size();
        endfunction

        function void note_fetch(in_item_t it);
            out_item_t        r;
            logic [SET_W-1:0] s;
            logic [TAG_W-1:0] t;
            logic [31:0]      old;
            int               base;
            int               m;
            int               w;
            s    = it.fetch_address[TAG_LSB-1:SET_LSB];
            t    = it.fetch_address[ADDR_W-1:TAG_LSB];
            base = int'(s) * WAYS;
            r    = '0;
            r.set_index = s;
            // lowest valid match wins
            m = -1;
            for (w = 0; w < WAYS; w++)
                if (m < 0 && line_valid[base + w] && line_tag[base + w] == t)
                    m = w;
            case (it.mode)
                MODE_LOOKUP:
                begin
                    if (m >= 0)
                    begin
                        r.hit = 1'b1;
                        r.way = WAY_W'(m);
                    end
                    else
                    begin
                        if (rr_mode)
                        begin
                            r.way     = rr_ptr[s];
                            rr_ptr[s] = rr_ptr[s] + 1'b1;
                        end
                        else
                        begin
                            old      = rnd_seed;
                            rnd_seed = rnd_seed ^ (old * SEED_MUL_A);
                            rnd_seed = rnd_seed ^ (old * SEED_MUL_B);
                            r.way    = rnd_seed[RND_LSB +: WAY_W];
                        end
                        line_tag[base + r.way]   = t;
                        line_valid[base + r.way] = 1'b1;
                        r.refill = 1'b1;
                    end
                end
                MODE_INVAL:
                begin
                    if (m >= 0)
                    begin
                        r.hit = 1'b1;
                        r.way = WAY_W'(m);
                        line_valid[base + m] = 1'b0;
                    end
                end
                MODE_INVAL_ALL:
                begin
                    for (w = 0; w < LINES; w++)
                        line_valid[w] = 1'b0;
                end
                default:
                begin
                end
            endcase
            expected_beats.push_back(r);
        endfunction

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_beats.size() == 0)
            begin
                report("unexpected beat", got, '0);
                return;
            end
            want = expected_beats.pop_front();
            if (got.hit !== want.hit)
                report("hit", got.hit, want.hit);
            if (got.way !== want.way)
                report("way", got.way, want.way);
            if (got.set_index !== want.set_index)
                report("set_index", got.set_index, want.set_index);
            if (got.refill !== want.refill)
                report("refill", got.refill, want.refill);
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    tag_array_shadow  shadow;
    bit               no_idle;
    int               hold_cycles;
    logic [TAG_W-1:0] tag_pool [6];
    logic [SET_W-1:0] set_pool [4];

    icache_tag_lookup_replace uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL icache_tag_lookup_replace");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (hold_cycles > 0)
            begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            shadow.check_result(out_data);
        end
    end

    // Hold valid across back-to-back beats; drop it only before a gap
    task automatic push_fetch(in_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        shadow.note_fetch(it);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_policy(logic rr);
        cfg_valid <= 1'b1;
        cfg_data  <= rr;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        shadow.rr_mode = rr;
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t mk_item(logic [1:0] m, logic [31:0] a);
        in_item_t it;
        it.mode          = m;
        it.fetch_address = a;
        return it;
    endfunction

    // Mostly lookups into a few hot sets with a few tags, so hits and evictions mix
    function automatic in_item_t pick_fetch();
        in_item_t it;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 78)
            it.mode = MODE_LOOKUP;
        else if (r < 92)
            it.mode = MODE_INVAL;
        else if (r < 95)
            it.mode = MODE_INVAL_ALL;
        else
            it.mode = MODE_UNUSED;
        if ($urandom_range(0, 9) < 7)
            it.fetch_address = {tag_pool[$urandom_range(0, 5)],
                                set_pool[$urandom_range(0, 3)], 5'($urandom)};
        else
            it.fetch_address = $urandom;
        return it;
    endfunction

    initial
    begin
        int i;
        int ph;
        int n;
        shadow      = new();
        no_idle     = 1'b0;
        hold_cycles = 0;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (i = 2; i < 6; i++)
            tag_pool[i] = TAG_W'($urandom);
        set_pool[0] = '0;
        set_pool[1] = '1;
        for (i = 2; i < 4; i++)
            set_pool[i] = SET_W'($urandom_range(1, SETS - 2));
        while (rst_n !== 1'b1)
            @(posedge clk);

        // random victims: edge addresses, invalidates, flash clear, unused mode
        drain_results();
        write_policy(1'b0);
        push_fetch(mk_item(MODE_LOOKUP, 32'h0000_0000));
        push_fetch(mk_item(MODE_LOOKUP, 32'h0000_001F));
        push_fetch(mk_item(MODE_LOOKUP, 32'hFFFF_FFFF));
        push_fetch(mk_item(MODE_LOOKUP, 32'hFFFF_FFE0));
        push_fetch(mk_item(MODE_INVAL, 32'hFFFF_FFFF));
        push_fetch(mk_item(MODE_INVAL, 32'hFFFF_FFFF));
        push_fetch(mk_item(MODE_LOOKUP, 32'hFFFF_FFFF));
        push_fetch(mk_item(MODE_UNUSED, 32'hFFFF_FFFF));
        push_fetch(mk_item(MODE_INVAL_ALL, 32'h1234_5678));
        push_fetch(mk_item(MODE_LOOKUP, 32'h0000_0000));
        push_fetch(mk_item(MODE_INVAL, 32'h8000_0000));

        // round-robin: fill one set past its ways, then probe the survivors
        drain_results();
        write_policy(1'b1);
        for (i = 1; i <= 5; i++)
            push_fetch(mk_item(MODE_LOOKUP, {21'(i), 6'd5, 5'd0}));
        push_fetch(mk_item(MODE_LOOKUP, {21'd1, 6'd5, 5'd0}));
        push_fetch(mk_item(MODE_LOOKUP, {21'd2, 6'd5, 5'd7}));
        push_fetch(mk_item(MODE_INVAL, {21'd3, 6'd5, 5'd31}));
        push_fetch(mk_item(MODE_LOOKUP, {21'd6, 6'd5, 5'd0}));

        for (ph = 0; ph < 4; ph++)
        begin
            drain_results();
            write_policy(ph[0]);
            for (n = 0; n < 250; n++)
            begin
                no_idle = (n >= 120 && n < 170);
                if (ph == 1 && n == 40)
                    hold_cycles = 80;
                if (ph == 2 && n == 100)
                    drain_results();
                push_fetch(pick_fetch());
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (20) @(posedge clk);
        if (shadow.pending() != 0)
            shadow.report("results never came", shadow.pending(), 0);
        if (shadow.mismatches == 0)
            $display("PASS icache_tag_lookup_replace");
        else
            $display("FAIL icache_tag_lookup_replace");
        $finish;
    end

endmodule
`default_nettype wire
